[sv/bpd_pkg.sv]
// ----------------------------------------------------------------------------
// bpd_pkg
// Shared types, codes and constants of the BMP pixel stream decoder.
// ----------------------------------------------------------------------------
package bpd_pkg;

	localparam int DEF_PALETTE_DEPTH = 256;
	localparam int DEF_MAX_DIMENSION = 256;
	localparam int DIM_CEILING       = 256;

	localparam int DIM_W      = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int ACTION_W   = 2;
	localparam int BYTE_W     = 8;
	localparam int COORD_W    = 8;
	localparam int COLOR_W    = 24;

	typedef enum logic [ACTION_W-1:0] {
		ACT_START     = 2'd0,
		ACT_PAL_WRITE = 2'd1,
		ACT_PIXEL     = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		FMT_4BPP  = 2'd0,
		FMT_8BPP  = 2'd1,
		FMT_24BPP = 2'd2
	} pixel_format_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXEL_FORMAT = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic               frame_end;
		logic               last;
	} pix_meta_t;

	typedef struct packed {
		logic               p0;
		logic               p1;
		pix_meta_t          m0;
		pix_meta_t          m1;
		logic               use_pal;
		logic [COLOR_W-1:0] rgb;
	} bpd_req_t;

endpackage

[sv/bpd_in_if.sv]
// ----------------------------------------------------------------------------
// bpd_in_if
// Input channel: one action word with palette write and pixel byte payload.
// ----------------------------------------------------------------------------
interface bpd_in_if import bpd_pkg::*;;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [BYTE_W-1:0]   palette_index;
	logic [COLOR_W-1:0]  palette_color;
	logic [BYTE_W-1:0]   data_byte;

	modport source (output valid, action, palette_index, palette_color, data_byte,
		input ready);
	modport sink (input valid, action, palette_index, palette_color, data_byte,
		output ready);
endinterface

[sv/bpd_out_if.sv]
// ----------------------------------------------------------------------------
// bpd_out_if
// Output channel: one addressed RGB pixel word.
// ----------------------------------------------------------------------------
interface bpd_out_if import bpd_pkg::*;;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] column;
	logic [COORD_W-1:0] row;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic               last_of_run;
	logic               frame_end;

	modport source (output valid, column, row, red, green, blue, last_of_run, frame_end,
		input ready);
	modport sink (input valid, column, row, red, green, blue, last_of_run, frame_end,
		output ready);
endinterface

[sv/bpd_palette.sv]
// ----------------------------------------------------------------------------
// bpd_palette
// RGB palette memory, one write port and two registered read ports.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module bpd_palette import bpd_pkg::*; #(
	parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH,
	localparam int AW = $clog2(PALETTE_DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [COLOR_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr0,
	input  logic [AW-1:0]      raddr1,
	input  logic               rhit0,
	output logic [COLOR_W-1:0] rdata0,
	output logic [COLOR_W-1:0] rdata1
);

	logic [COLOR_W-1:0]       mem [PALETTE_DEPTH];
	logic [PALETTE_DEPTH-1:0] valid_q;
	logic [COLOR_W-1:0]       rd0_s1;
	logic [COLOR_W-1:0]       rd1_s1;
	logic                     vld0_s1;
	logic                     vld1_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd0_s1 <= mem[raddr0];
			rd1_s1 <= mem[raddr1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld0_s1 <= 1'b0;
			vld1_s1 <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				vld0_s1 <= valid_q[raddr0] & rhit0;
				vld1_s1 <= valid_q[raddr1];
			end
		end
	end

	assign rdata0 = vld0_s1 ? rd0_s1 : '0;
	assign rdata1 = vld1_s1 ? rd1_s1 : '0;

endmodule

[sv/bpd_frame_ctrl.sv]
// ----------------------------------------------------------------------------
// bpd_frame_ctrl
// Configuration registers, position counters, 24 bpp byte assembly and row
// padding. Decides which pixels a byte emits and issues palette reads.
// ----------------------------------------------------------------------------
module bpd_frame_ctrl import bpd_pkg::*; #(
	parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH,
	parameter int MAX_DIMENSION = DEF_MAX_DIMENSION,
	localparam int AW = $clog2(PALETTE_DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  accept,
	input  logic [ACTION_W-1:0]   action,
	input  logic [BYTE_W-1:0]     data_byte,
	output logic                  load,
	output bpd_req_t              req,
	output logic [AW-1:0]         rd_addr0,
	output logic [AW-1:0]         rd_addr1,
	output logic                  rd_hit0
);

	localparam int DIM_LIM_INT = (MAX_DIMENSION < DIM_CEILING) ? MAX_DIMENSION : DIM_CEILING;
	localparam logic [DIM_W-1:0] DIM_LIM = DIM_W'(DIM_LIM_INT);
	localparam logic [DIM_W-1:0] DEPTH_CMP = DIM_W'(PALETTE_DEPTH);

	localparam logic [1:0] PH_BLUE  = 2'd0;
	localparam logic [1:0] PH_GREEN = 2'd1;
	localparam logic [1:0] PH_RED   = 2'd2;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [1:0]         pad;
		logic               done;
	} fstate_t;

	typedef struct packed {
		logic      ok;
		pix_meta_t meta;
		fstate_t   nxt;
	} emit_t;

	function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] d;
		d = v;
		if (d == '0) d = DIM_W'(1);
		if (d > DIM_LIM) d = DIM_LIM;
		return d;
	endfunction

	function automatic emit_t emit(fstate_t s, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
		logic pad_rows);
		emit_t            r;
		logic [DIM_W-1:0] col_inc;
		logic [DIM_W-1:0] row_inc;
		r.nxt = s;
		r.ok = !s.done && ({1'b0, s.row} < h);
		col_inc = {1'b0, s.col} + DIM_W'(1);
		row_inc = {1'b0, s.row} + DIM_W'(1);
		r.meta.column = s.col;
		r.meta.row = COORD_W'(h - DIM_W'(1) - {1'b0, s.row});
		r.meta.frame_end = 1'b0;
		r.meta.last = 1'b0;
		if (r.ok) begin
			r.nxt.col = col_inc[COORD_W-1:0];
			if (col_inc >= w) begin
				r.nxt.col = '0;
				r.nxt.row = row_inc[COORD_W-1:0];
				if (row_inc >= h) begin
					r.nxt.done = 1'b1;
					r.meta.frame_end = 1'b1;
				end
				if (pad_rows) r.nxt.pad = w[1:0];
			end
		end
		return r;
	endfunction

	logic [1:0]       fmt_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;

	fstate_t cur;
	fstate_t nxt;
	emit_t   e0;
	emit_t   e1;

	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic [1:0]         pad_q;
	logic               done_q;
	logic [1:0]         phase_q;
	logic [1:0]         phase_d;
	logic [15:0]        part_q;
	logic [15:0]        part_d;

	assign w_eff = eff_dim(width_q);
	assign h_eff = eff_dim(height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_8BPP;
			width_q  <= DIM_W'(16);
			height_q <= DIM_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PIXEL_FORMAT: fmt_q <= cfg_data[1:0];
				REG_IMAGE_WIDTH:  width_q <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cur.col  = col_q;
		cur.row  = row_q;
		cur.pad  = pad_q;
		cur.done = done_q;
		e0 = emit(cur, w_eff, h_eff, fmt_q == FMT_24BPP);
		e1 = emit(e0.nxt, w_eff, h_eff, 1'b0);
		nxt = cur;
		phase_d = phase_q;
		part_d = part_q;
		req = '0;
		if (accept) begin
			case (action)
				ACT_START: begin
					nxt = '0;
					phase_d = PH_BLUE;
					part_d = '0;
				end
				ACT_PIXEL: begin
					case (fmt_q)
						FMT_8BPP: begin
							req.p0 = e0.ok;
							req.m0 = e0.meta;
							req.m0.last = 1'b1;
							req.use_pal = 1'b1;
							nxt = e0.nxt;
						end
						FMT_4BPP: begin
							req.p0 = e0.ok;
							req.p1 = e1.ok;
							req.m0 = e0.meta;
							req.m0.last = !e1.ok;
							req.m1 = e1.meta;
							req.m1.last = 1'b1;
							req.use_pal = 1'b1;
							nxt = e1.nxt;
						end
						FMT_24BPP: begin
							if (pad_q != 2'd0) begin
								nxt.pad = pad_q - 2'd1;
							end else begin
								case (phase_q)
									PH_BLUE: begin
										part_d = {8'h00, data_byte};
										phase_d = PH_GREEN;
									end
									PH_GREEN: begin
										part_d = {data_byte, part_q[7:0]};
										phase_d = PH_RED;
									end
									default: begin
										phase_d = PH_BLUE;
										req.p0 = e0.ok;
										req.m0 = e0.meta;
										req.m0.last = 1'b1;
										req.rgb = {data_byte, part_q};
										nxt = e0.nxt;
									end
								endcase
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	assign load = req.p0;

	always_comb begin
		rd_addr1 = AW'(data_byte[3:0]);
		if (fmt_q == FMT_4BPP) begin
			rd_addr0 = AW'(data_byte[7:4]);
			rd_hit0  = 1'b1;
		end else begin
			rd_hit0  = ({1'b0, data_byte} < DEPTH_CMP);
			rd_addr0 = rd_hit0 ? data_byte[AW-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			pad_q   <= '0;
			done_q  <= 1'b0;
			phase_q <= PH_BLUE;
			part_q  <= '0;
		end else begin
			col_q   <= nxt.col;
			row_q   <= nxt.row;
			pad_q   <= nxt.pad;
			done_q  <= nxt.done;
			phase_q <= phase_d;
			part_q  <= part_d;
		end
	end

endmodule

[sv/bpd_out_stage.sv]
// ----------------------------------------------------------------------------
// bpd_out_stage
// Holds the pixels of one byte next to the palette read data and feeds them,
// one word at a time, into the output register.
// ----------------------------------------------------------------------------
module bpd_out_stage import bpd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  bpd_req_t           req,
	input  logic [COLOR_W-1:0] rdata0,
	input  logic [COLOR_W-1:0] rdata1,
	output logic               free,
	bpd_out_if.source          pixel_out
);

	logic               p0_s1;
	logic               p1_s1;
	pix_meta_t          m0_s1;
	pix_meta_t          m1_s1;
	logic               use_pal_s1;
	logic [COLOR_W-1:0] rgb_s1;

	logic               out_valid_q;
	pix_meta_t          out_meta_q;
	logic [COLOR_W-1:0] out_color_q;

	logic               pend;
	logic               mv;
	pix_meta_t          sel_meta;
	logic [COLOR_W-1:0] sel_color;

	assign pend = p0_s1 | p1_s1;
	assign mv   = pend && (!out_valid_q || pixel_out.ready);
	assign free = !pend || (mv && !(p0_s1 && p1_s1));

	assign sel_meta  = p0_s1 ? m0_s1 : m1_s1;
	assign sel_color = p0_s1 ? (use_pal_s1 ? rdata0 : rgb_s1) : rdata1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p0_s1       <= 1'b0;
			p1_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				p0_s1 <= req.p0;
				p1_s1 <= req.p1;
			end else if (mv) begin
				if (p0_s1) p0_s1 <= 1'b0;
				else p1_s1 <= 1'b0;
			end
			if (mv) out_valid_q <= 1'b1;
			else if (pixel_out.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m0_s1      <= req.m0;
			m1_s1      <= req.m1;
			use_pal_s1 <= req.use_pal;
			rgb_s1     <= req.rgb;
		end
		if (mv) begin
			out_meta_q  <= sel_meta;
			out_color_q <= sel_color;
		end
	end

	assign pixel_out.valid       = out_valid_q;
	assign pixel_out.column      = out_meta_q.column;
	assign pixel_out.row         = out_meta_q.row;
	assign pixel_out.red         = out_color_q[23:16];
	assign pixel_out.green       = out_color_q[15:8];
	assign pixel_out.blue        = out_color_q[7:0];
	assign pixel_out.last_of_run = out_meta_q.last;
	assign pixel_out.frame_end   = out_meta_q.frame_end;

endmodule

[sv/bmp_pixel_stream_decoder_top.sv]
// ----------------------------------------------------------------------------
// bmp_pixel_stream_decoder_top
// Turns BMP pixel area bytes (4, 8 or 24 bpp) into addressed RGB pixels.
//
//   channel     dir   word                                      accepted when
//   byte_in     in    action, palette_index/color, data_byte    valid & ready
//   pixel_out   out   column, row, red, green, blue, flags      valid & ready
//   cfg         in    cfg_index, cfg_data                       cfg_we
//
// 8 bpp and 24 bpp take one byte a cycle unless the output stalls; with 4 bpp
// a byte of two pixels keeps byte_in.ready low until the first has left, as
// both share the output register that follows the palette read register.
// Reset clears the palette valid bits at once; no clearing pass is needed.
// A stalled output holds the pixel stage, which drops byte_in.ready.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_decoder_top import bpd_pkg::*; #(
	parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH,
	parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bpd_in_if.sink                byte_in,
	bpd_out_if.source             pixel_out
);

	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam logic [DIM_W-1:0] DEPTH_CMP = DIM_W'(PALETTE_DEPTH);

	logic               accept;
	logic               free;
	logic               load;
	bpd_req_t           req;
	logic [AW-1:0]      rd_addr0;
	logic [AW-1:0]      rd_addr1;
	logic               rd_hit0;
	logic               pal_we;
	logic [COLOR_W-1:0] rdata0;
	logic [COLOR_W-1:0] rdata1;

	assign byte_in.ready = free;
	assign accept = byte_in.valid && free;
	assign pal_we = accept && (byte_in.action == ACT_PAL_WRITE)
		&& ({1'b0, byte_in.palette_index} < DEPTH_CMP);

	bpd_frame_ctrl #(
		.PALETTE_DEPTH(PALETTE_DEPTH),
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.action    (byte_in.action),
		.data_byte (byte_in.data_byte),
		.load      (load),
		.req       (req),
		.rd_addr0  (rd_addr0),
		.rd_addr1  (rd_addr1),
		.rd_hit0   (rd_hit0)
	);

	bpd_palette #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (pal_we),
		.waddr  (byte_in.palette_index[AW-1:0]),
		.wdata  (byte_in.palette_color),
		.re     (load),
		.raddr0 (rd_addr0),
		.raddr1 (rd_addr1),
		.rhit0  (rd_hit0),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	bpd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.req       (req),
		.rdata0    (rdata0),
		.rdata1    (rdata1),
		.free      (free),
		.pixel_out (pixel_out)
	);

`ifndef SYNTHESIS
	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_out.valid && pixel_out.frame_end |-> pixel_out.last_of_run)
		else $error("frame end pixel not marked last of run");

	a_no_load_non_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (byte_in.action != ACT_PIXEL) |-> !load)
		else $error("pixel stage loaded by a non-pixel word");

	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		load && req.p1 |-> req.p0)
		else $error("second pixel emitted without the first");
`endif

endmodule
